// File: hdl/eatrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eatrt_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int CW = 33;
	localparam int ZW = 33;
	localparam int TW = 32;
	localparam int AW = 16;
	localparam int MW = 16;

	localparam logic signed [ZW-1:0] ANG_PI = 33'sd1686629713;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 33'sd843314856;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [ZW-1:0] ang_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		ang_t z;
		logic neg;
	} rot_t;

	function automatic ang_t atan_step(input int i);
		ang_t r;
		case (i)
			0: r = 33'sd421657428;
			1: r = 33'sd248918915;
			2: r = 33'sd131521918;
			3: r = 33'sd66762579;
			4: r = 33'sd33510843;
			5: r = 33'sd16771758;
			6: r = 33'sd8387925;
			7: r = 33'sd4194219;
			8: r = 33'sd2097141;
			9: r = 33'sd1048575;
			10: r = 33'sd524288;
			11: r = 33'sd262144;
			12: r = 33'sd131072;
			13: r = 33'sd65536;
			14: r = 33'sd32768;
			15: r = 33'sd16384;
			16: r = 33'sd8192;
			17: r = 33'sd4096;
			18: r = 33'sd2048;
			19: r = 33'sd1024;
			20: r = 33'sd512;
			21: r = 33'sd256;
			22: r = 33'sd128;
			23: r = 33'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic coord_t mulq(input coord_t a, input coord_t b);
		logic signed [2*CW-1:0] p;
		p = a * b + (66'sd1 <<< 29);
		return coord_t'(p >>> 30);
	endfunction

	function automatic logic signed [MW-1:0] to_q14(input logic signed [CW+1:0] v);
		logic signed [CW+1:0] r;
		r = (v + 35'sd32768) >>> 16;
		if (r > 35'sd16384)
			r = 35'sd16384;
		if (r < -35'sd16384)
			r = -35'sd16384;
		return r[MW-1:0];
	endfunction
endpackage
`default_nettype wire

// File: hdl/eatrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module eatrt_cell (
	input wire logic clk,
	input wire logic [4:0] idx,
	input wire eatrt_pkg::rot_t din,
	output eatrt_pkg::rot_t dout
);
	import eatrt_pkg::*;
	coord_t dx;
	coord_t dy;
	ang_t a;
	rot_t nx;

	always_comb begin
		dx = din.y >>> idx;
		dy = din.x >>> idx;
		a = atan_step(int'(idx));
		nx.neg = din.neg;
		if (!din.z[ZW-1]) begin
			nx.x = din.x - dx;
			nx.y = din.y + dy;
			nx.z = din.z - a;
		end else begin
			nx.x = din.x + dx;
			nx.y = din.y - dy;
			nx.z = din.z + a;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nx;
	end
endmodule
`default_nettype wire

// File: hdl/eatrt_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
module eatrt_sincos (
	input wire logic clk,
	input wire logic signed [eatrt_pkg::AW-1:0] angle,
	output eatrt_pkg::coord_t cos_v,
	output eatrt_pkg::coord_t sin_v
);
	import eatrt_pkg::*;
	rot_t chain [0:CORDIC_STAGES];
	ang_t z0;

	always_comb begin
		z0 = ang_t'(angle) <<< 16;
		chain[0].x = CORDIC_GAIN;
		chain[0].y = '0;
		chain[0].neg = 1'b0;
		chain[0].z = z0;
		if (z0 > ANG_HALF_PI) begin
			chain[0].z = ANG_PI - z0;
			chain[0].neg = 1'b1;
		end else if (z0 < -ANG_HALF_PI) begin
			chain[0].z = -ANG_PI - z0;
			chain[0].neg = 1'b1;
		end
	end

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		eatrt_cell u_cell (
			.clk(clk),
			.idx(5'(g)),
			.din(chain[g]),
			.dout(chain[g+1])
		);
	end

	assign cos_v = chain[CORDIC_STAGES].neg ? -chain[CORDIC_STAGES].x
		: chain[CORDIC_STAGES].x;
	assign sin_v = chain[CORDIC_STAGES].y;
endmodule
`default_nettype wire

// File: hdl/euler_angles_to_rigid_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// Euler ZYX (yaw, pitch, roll) to the top three rows of a rigid transform.
// Drive the angles and translation with start high for one cycle; an item
// is taken at each edge where start is high and busy is low. busy is always
// low, so an item can be presented every cycle.
// Each angle runs through its own chain of CORDIC_STAGES pipelined cells,
// then two product stages and one rounding stage form the matrix entries.
// Throughput is one item per cycle, set by the cell chain and the
// product pipeline.
// The result shows on m00..m22 and out_shift_x/y/z for one cycle with
// done high. The receiver cannot stall, so nothing is held back.
// Reset clears the valid pipeline only; no item in flight survives it.
module euler_angles_to_rigid_transform (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [15:0] yaw_angle,
	input wire logic signed [15:0] pitch_angle,
	input wire logic signed [15:0] roll_angle,
	input wire logic signed [31:0] shift_x,
	input wire logic signed [31:0] shift_y,
	input wire logic signed [31:0] shift_z,
	output logic done,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic signed [31:0] out_shift_x,
	output logic signed [31:0] out_shift_y,
	output logic signed [31:0] out_shift_z
);
	import eatrt_pkg::*;
	localparam int LAT = CORDIC_STAGES + 3;

	coord_t cy, sy, cp, sp, cr, sr;
	logic [LAT-1:0] vld_q;
	logic signed [TW-1:0] tx_q [0:LAT-1];
	logic signed [TW-1:0] ty_q [0:LAT-1];
	logic signed [TW-1:0] tz_q [0:LAT-1];

	coord_t cpcy_s1, cysp_s1, crsy_s1, crcy_s1, srsy_s1, cpsy_s1, spsr_s1;
	coord_t cysr_s1, crsp_s1, cpsr_s1, cpcr_s1, sp_s1, sr_s1, sy_s1;
	coord_t cpcy_s2, a01_s2, crsy_s2, a02_s2, srsy_s2, cpsy_s2, crcy_s2;
	coord_t a11_s2, cysr_s2, a12_s2, sp_s2, cpsr_s2, cpcr_s2;

	assign busy = 1'b0;

	eatrt_sincos u_yaw (.clk(clk), .angle(yaw_angle), .cos_v(cy), .sin_v(sy));
	eatrt_sincos u_pitch (.clk(clk), .angle(pitch_angle), .cos_v(cp), .sin_v(sp));
	eatrt_sincos u_roll (.clk(clk), .angle(roll_angle), .cos_v(cr), .sin_v(sr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		tx_q[0] <= shift_x;
		ty_q[0] <= shift_y;
		tz_q[0] <= shift_z;
		for (int i = 1; i < LAT; i++) begin
			tx_q[i] <= tx_q[i-1];
			ty_q[i] <= ty_q[i-1];
			tz_q[i] <= tz_q[i-1];
		end
		cpcy_s1 <= mulq(cp, cy);
		cysp_s1 <= mulq(cy, sp);
		crsy_s1 <= mulq(cr, sy);
		crcy_s1 <= mulq(cr, cy);
		srsy_s1 <= mulq(sr, sy);
		cpsy_s1 <= mulq(cp, sy);
		spsr_s1 <= mulq(sp, sr);
		cysr_s1 <= mulq(cy, sr);
		crsp_s1 <= mulq(cr, sp);
		cpsr_s1 <= mulq(cp, sr);
		cpcr_s1 <= mulq(cp, cr);
		sp_s1 <= sp;
		sr_s1 <= sr;
		sy_s1 <= sy;
		cpcy_s2 <= cpcy_s1;
		a01_s2 <= mulq(cysp_s1, sr_s1);
		crsy_s2 <= crsy_s1;
		a02_s2 <= mulq(crcy_s1, sp_s1);
		srsy_s2 <= srsy_s1;
		cpsy_s2 <= cpsy_s1;
		crcy_s2 <= crcy_s1;
		a11_s2 <= mulq(spsr_s1, sy_s1);
		cysr_s2 <= cysr_s1;
		a12_s2 <= mulq(crsp_s1, sy_s1);
		sp_s2 <= sp_s1;
		cpsr_s2 <= cpsr_s1;
		cpcr_s2 <= cpcr_s1;
		m00 <= to_q14(35'(cpcy_s2));
		m01 <= to_q14(35'(a01_s2) - 35'(crsy_s2));
		m02 <= to_q14(35'(a02_s2) + 35'(srsy_s2));
		m10 <= to_q14(35'(cpsy_s2));
		m11 <= to_q14(35'(crcy_s2) + 35'(a11_s2));
		m12 <= to_q14(35'(a12_s2) - 35'(cysr_s2));
		m20 <= to_q14(-35'(sp_s2));
		m21 <= to_q14(35'(cpsr_s2));
		m22 <= to_q14(35'(cpcr_s2));
	end

	assign done = vld_q[LAT-1];
	assign out_shift_x = tx_q[LAT-1];
	assign out_shift_y = ty_q[LAT-1];
	assign out_shift_z = tz_q[LAT-1];

`ifndef ASSERT_OFF
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(LAT) done) else $error("result missing");
	a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
	a_m20: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (m20 <= 16'sd16384 && m20 >= -16'sd16384)) else $error("m20 range");
`endif
endmodule
`default_nettype wire

// File: tb/euler_angles_to_rigid_transform_tb.sv
`timescale 1ns / 1ps
module euler_angles_to_rigid_transform_tb;
	import eatrt_pkg::*;

	typedef struct {
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		int gap;
	} pose_t;

	typedef struct {
		logic signed [15:0] m [9];
		logic signed [31:0] t [3];
	} xform_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] yaw_angle = '0;
	logic signed [15:0] pitch_angle = '0;
	logic signed [15:0] roll_angle = '0;
	logic signed [31:0] shift_x = '0;
	logic signed [31:0] shift_y = '0;
	logic signed [31:0] shift_z = '0;
	logic done;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [31:0] out_shift_x, out_shift_y, out_shift_z;

	pose_t pending_poses[$];
	xform_t expected_xforms[$];
	int errors = 0;
	int wait_left = 0;
	bit feeding = 1'b0;

	euler_angles_to_rigid_transform DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle),
		.shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z),
		.done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
		.m12(m12), .m20(m20), .m21(m21), .m22(m22),
		.out_shift_x(out_shift_x), .out_shift_y(out_shift_y), .out_shift_z(out_shift_z)
	);

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint arctan_q29(int i);
		longint unsigned acc;
		longint unsigned term;
		int p;
		acc = 0;
		if (i == 0)
			return 64'd421657428;
		for (int k = 0; k <= 40; k++) begin
			p = i * (2 * k + 1);
			if (p > 62)
				break;
			term = (64'd1 << (62 - p)) / longint'(2 * k + 1);
			if (k % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		return longint'((acc + (64'd1 << 32)) >> 33);
	endfunction

	function automatic void sine_cosine(input logic signed [15:0] ang, output longint c,
			output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = longint'(ang) * 65536;
		x = 652032874;
		y = 0;
		flip = 1'b0;
		if (z > 843314856) begin
			z = 1686629713 - z;
			flip = 1'b1;
		end else if (z < -843314856) begin
			z = -1686629713 - z;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_q29(i);
			end else begin
				x += dx; y -= dy; z += arctan_q29(i);
			end
		end
		c = flip ? -x : x;
		s = y;
	endfunction

	function automatic longint fmul(longint a, longint b);
		return shr_floor(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic signed [15:0] entry_q14(longint v);
		longint r;
		r = shr_floor(v + 32768, 16);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r[15:0];
	endfunction

	function automatic xform_t rigid_transform(pose_t p);
		xform_t e;
		longint cy, sy, cp, sp, cr, sr;
		sine_cosine(p.yaw, cy, sy);
		sine_cosine(p.pitch, cp, sp);
		sine_cosine(p.roll, cr, sr);
		e.m[0] = entry_q14(fmul(cp, cy));
		e.m[1] = entry_q14(fmul(fmul(cy, sp), sr) - fmul(cr, sy));
		e.m[2] = entry_q14(fmul(fmul(cr, cy), sp) + fmul(sr, sy));
		e.m[3] = entry_q14(fmul(cp, sy));
		e.m[4] = entry_q14(fmul(cr, cy) + fmul(fmul(sp, sr), sy));
		e.m[5] = entry_q14(-fmul(cy, sr) + fmul(fmul(cr, sp), sy));
		e.m[6] = entry_q14(-sp);
		e.m[7] = entry_q14(fmul(cp, sr));
		e.m[8] = entry_q14(fmul(cp, cr));
		e.t[0] = p.tx;
		e.t[1] = p.ty;
		e.t[2] = p.tz;
		return e;
	endfunction

	function automatic logic signed [15:0] any_angle();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'(25736 - $urandom_range(0, 40));
			2: return 16'(-25736 + $urandom_range(0, 40));
			3: return 16'(12868 + $urandom_range(0, 20) - 10);
			4: return 16'(-12868 + $urandom_range(0, 20) - 10);
			default: return 16'($urandom_range(0, 51472) - 25736);
		endcase
	endfunction

	task automatic queue_pose(input logic signed [15:0] ya, pa, ra,
			input logic signed [31:0] x, y, z);
		pose_t p;
		p.yaw = ya; p.pitch = pa; p.roll = ra;
		p.tx = x; p.ty = y; p.tz = z;
		case ($urandom_range(0, 3))
			0: p.gap = $urandom_range(0, 15);
			default: p.gap = 0;
		endcase
		pending_poses.push_back(p);
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		logic signed [15:0] corner [9];
		corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
			16'sd32767, -16'sd32768, 16'sd12869, -16'sd12869};
		foreach (corner[i])
			queue_pose(corner[i], corner[(i + 3) % 9], corner[(i + 6) % 9],
				32'h7fffffff, 32'h80000000, 32'h0);
		queue_pose(16'sd6434, 16'sd6434, 16'sd6434, -1, 0, 32'h55555555);
		queue_pose(16'sd12868, 16'sd12868, 16'sd0, 32'haaaaaaaa, -1, 1);
		queue_pose(-16'sd25736, 16'sd12868, -16'sd12868, 1, 2, 3);
		for (int n = 0; n < 450; n++)
			queue_pose(any_angle(), any_angle(), any_angle(), $urandom, $urandom, $urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		feeding <= 1'b1;
	end

	always @(posedge clk) begin
		pose_t p;
		if (feeding) begin
			if (!(start && busy)) begin
				if (wait_left > 0) begin
					wait_left <= wait_left - 1;
					start <= 1'b0;
				end else if (pending_poses.size() > 0) begin
					p = pending_poses.pop_front();
					yaw_angle <= p.yaw;
					pitch_angle <= p.pitch;
					roll_angle <= p.roll;
					shift_x <= p.tx;
					shift_y <= p.ty;
					shift_z <= p.tz;
					start <= 1'b1;
					wait_left <= p.gap;
					expected_xforms.push_back(rigid_transform(p));
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		xform_t e;
		logic signed [15:0] got [9];
		logic signed [31:0] tgot [3];
		if (arst_n && done) begin
			got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			tgot = '{out_shift_x, out_shift_y, out_shift_z};
			if (expected_xforms.size() == 0) begin
				$display("%0t: result with no item pending", $time);
				errors++;
			end else begin
				e = expected_xforms.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== e.m[i]) begin
						$display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
							e.m[i], got[i]);
						errors++;
					end
				for (int i = 0; i < 3; i++)
					if (tgot[i] !== e.t[i]) begin
						$display("%0t: out_shift[%0d] expected %0d actual %0d", $time, i,
							e.t[i], tgot[i]);
						errors++;
					end
			end
		end
	end

	initial begin
		wait (feeding);
		wait (pending_poses.size() == 0 && !start);
		wait (expected_xforms.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end
endmodule
